[rtl/bgch_pkg.sv]
// Shared types and constants for the battery gauge / charge hysteresis core.
// Beat structs, configuration struct, register indexes and Q48 polynomial coefficients.
// No dependencies.
package bgch_pkg;

	localparam int CODE_W  = 12;
	localparam int LEVEL_W = 14;
	localparam int PCT_W   = 7;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	typedef struct packed {
		logic [CODE_W-1:0] adc_code;
		logic              power_connected;
	} in_beat_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] battery_mv;
		logic               charge_enable;
		logic [PCT_W-1:0]   percent;
	} out_beat_t;

	typedef struct packed {
		logic signed [11:0]  adc_offset_mv;
		logic [19:0]         divider_inverse_q16;
		logic [LEVEL_W-1:0]  empty_mv;
		logic [LEVEL_W-1:0]  full_mv;
		logic [LEVEL_W-1:0]  target_mv;
		logic [LEVEL_W-1:0]  hysteresis_mv;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_ADC_OFFSET  = 3'd0,
		REG_DIV_INVERSE = 3'd1,
		REG_EMPTY       = 3'd2,
		REG_FULL        = 3'd3,
		REG_TARGET      = 3'd4,
		REG_HYSTERESIS  = 3'd5
	} reg_idx_t;

	localparam logic signed [11:0]  RST_OFFSET  = 12'sd0;
	localparam logic [19:0]         RST_INVERSE = 20'd65536;
	localparam logic [LEVEL_W-1:0]  RST_EMPTY   = 14'd3300;
	localparam logic [LEVEL_W-1:0]  RST_FULL    = 14'd4200;
	localparam logic [LEVEL_W-1:0]  RST_TARGET  = 14'd4100;
	localparam logic [LEVEL_W-1:0]  RST_HYST    = 14'd100;

	// Linearization polynomial in mV, coefficients scaled by 2^48
	localparam logic signed [63:0] POLY_C4 = -64'sd4504;
	localparam logic signed [63:0] POLY_C3 = 64'sd33262179;
	localparam logic signed [63:0] POLY_C2 = -64'sd84783553709;
	localparam logic signed [63:0] POLY_C1 = 64'sd312161173698885;
	localparam logic signed [63:0] POLY_C0 = 64'sd9610547801199911;

	localparam logic signed [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] INT64_MIN = {1'b1, {63{1'b0}}};

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
	localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;

	// Coefficient added after Horner step n (0..3), highest power first
	function automatic logic signed [63:0] poly_coef(input logic [1:0] step);
		logic signed [63:0] c;
		case (step)
			2'd0:    c = POLY_C3;
			2'd1:    c = POLY_C2;
			2'd2:    c = POLY_C1;
			default: c = POLY_C0;
		endcase
		return c;
	endfunction

endpackage

[rtl/bgch_regs.sv]
// Configuration register file behind an APB-style port.
// Depends on bgch_pkg (cfg_t, reg_idx_t, reset values).
module bgch_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgch_pkg::ADDR_W-1:0] paddr,
	input  logic [bgch_pkg::DATA_W-1:0] pwdata,
	output logic [bgch_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output bgch_pkg::cfg_t              cfg
);

	bgch_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_offset_mv       <= bgch_pkg::RST_OFFSET;
			cfg_q.divider_inverse_q16 <= bgch_pkg::RST_INVERSE;
			cfg_q.empty_mv            <= bgch_pkg::RST_EMPTY;
			cfg_q.full_mv             <= bgch_pkg::RST_FULL;
			cfg_q.target_mv           <= bgch_pkg::RST_TARGET;
			cfg_q.hysteresis_mv       <= bgch_pkg::RST_HYST;
		end else if (wr_en) begin
			case (idx)
				bgch_pkg::REG_ADC_OFFSET:  cfg_q.adc_offset_mv       <= $signed(pwdata[11:0]);
				bgch_pkg::REG_DIV_INVERSE: cfg_q.divider_inverse_q16 <= pwdata[19:0];
				bgch_pkg::REG_EMPTY:       cfg_q.empty_mv            <= pwdata[13:0];
				bgch_pkg::REG_FULL:        cfg_q.full_mv             <= pwdata[13:0];
				bgch_pkg::REG_TARGET:      cfg_q.target_mv           <= pwdata[13:0];
				bgch_pkg::REG_HYSTERESIS:  cfg_q.hysteresis_mv       <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			bgch_pkg::REG_ADC_OFFSET:  prdata = {{20{cfg_q.adc_offset_mv[11]}}, cfg_q.adc_offset_mv};
			bgch_pkg::REG_DIV_INVERSE: prdata = {12'd0, cfg_q.divider_inverse_q16};
			bgch_pkg::REG_EMPTY:       prdata = {18'd0, cfg_q.empty_mv};
			bgch_pkg::REG_FULL:        prdata = {18'd0, cfg_q.full_mv};
			bgch_pkg::REG_TARGET:      prdata = {18'd0, cfg_q.target_mv};
			bgch_pkg::REG_HYSTERESIS:  prdata = {18'd0, cfg_q.hysteresis_mv};
			default:                   prdata = '0;
		endcase
	end

endmodule

[rtl/bgch_front.sv]
// Front end: accepts input beats, masks the code to ADC_BITS and queues them (2 deep).
// Depends on bgch_pkg (in_beat_t, CODE_W).
module bgch_front #(
	parameter int ADC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bgch_pkg::in_beat_t   in_beat,
	output logic                 q_valid,
	input  logic                 q_pop,
	output logic [ADC_BITS-1:0]  q_code,
	output logic                 q_power
);

	localparam int ENT_W = ADC_BITS + 1;

	logic [ENT_W-1:0]                          fifo_q [2];
	logic                                      wr_ptr_q;
	logic                                      rd_ptr_q;
	logic [1:0]                                count_q;
	logic [bgch_pkg::CODE_W+ADC_BITS-1:0]      code_ext;
	logic                                      push;
	logic                                      pop;

	// zero-extend, then keep the low ADC_BITS bits
	assign code_ext = {{ADC_BITS{1'b0}}, in_beat.adc_code};

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid & ~in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop & q_valid;

	assign q_code  = fifo_q[rd_ptr_q][ENT_W-1:1];
	assign q_power = fifo_q[rd_ptr_q][0];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {code_ext[ADC_BITS-1:0], in_beat.power_connected};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/bgch_back.sv]
// Back end: bit-serial Horner evaluation, scaling, charger hysteresis, percent divider,
// and the output register. Depends on bgch_pkg (beat/config types, coefficients).
module bgch_back #(
	parameter int ADC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bgch_pkg::cfg_t       cfg,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  logic [ADC_BITS-1:0]  q_code,
	input  logic                 q_power,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bgch_pkg::out_beat_t  out_beat
);

	localparam int P_W   = 64 + ADC_BITS;
	localparam int CNT_W = $clog2(ADC_BITS);
	localparam logic [CNT_W-1:0] BIT_TOP = CNT_W'(ADC_BITS - 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MULT  = 9'b000000010,
		ST_ADD   = 9'b000000100,
		ST_ROUND = 9'b000001000,
		ST_SCALE = 9'b000010000,
		ST_LEVEL = 9'b000100000,
		ST_CLASS = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t                       state_q;
	logic [ADC_BITS-1:0]          x_q;
	logic                         power_q;
	logic signed [63:0]           acc_q;
	logic signed [P_W-1:0]        p_q;
	logic [CNT_W-1:0]             bit_q;
	logic [1:0]                   step_q;
	logic signed [17:0]           mv_q;
	logic signed [39:0]           prod_q;
	logic [13:0]                  lvl_q;
	logic [20:0]                  rem_q;
	logic [13:0]                  den_q;
	logic [2:0]                   div_q;
	logic [6:0]                   pct_q;
	logic                         charge_on_q;
	logic                         out_valid_q;
	bgch_pkg::out_beat_t          out_q;

	logic signed [P_W-1:0]        p_next;
	logic signed [63:0]           m_sat;
	logic signed [63:0]           coef;
	logic signed [64:0]           sum;
	logic signed [63:0]           acc_next;
	logic signed [16:0]           q_mv;
	logic signed [38:0]           prod_w;
	logic [20:0]                  trial;
	logic [13:0]                  diff;
	logic signed [14:0]           lvl_s;
	logic signed [14:0]           thr;
	logic                         charge_next;
	logic                         out_free;

	// shift-add partial product, code bit MSB first
	assign p_next = {p_q[P_W-2:0], 1'b0}
		+ (x_q[bit_q] ? {{ADC_BITS{acc_q[63]}}, acc_q} : P_W'(0));

	assign coef = bgch_pkg::poly_coef(step_q);

	// saturate product to 64 bits, then saturating add of the coefficient
	always_comb begin
		if ((&p_q[P_W-1:63]) || !(|p_q[P_W-1:63])) begin
			m_sat = p_q[63:0];
		end else begin
			m_sat = p_q[P_W-1] ? bgch_pkg::INT64_MIN : bgch_pkg::INT64_MAX;
		end
		sum = {m_sat[63], m_sat} + {coef[63], coef};
		if (sum[64] != sum[63]) begin
			acc_next = sum[64] ? bgch_pkg::INT64_MIN : bgch_pkg::INT64_MAX;
		end else begin
			acc_next = sum[63:0];
		end
	end

	// floor of Q48 plus round-half-up
	assign q_mv   = {acc_q[63], acc_q[63:48]} + {16'd0, acc_q[47]};
	assign prod_w = mv_q * $signed({1'b0, cfg.divider_inverse_q16});
	assign trial  = 21'(den_q) << div_q;
	assign diff   = lvl_q - cfg.empty_mv;

	// charger hysteresis
	assign lvl_s = $signed({1'b0, lvl_q});
	assign thr   = $signed({1'b0, cfg.target_mv}) - $signed({1'b0, cfg.hysteresis_mv});
	always_comb begin
		charge_next = charge_on_q;
		if (power_q) begin
			if (charge_on_q && (lvl_q >= cfg.target_mv)) begin
				charge_next = 1'b0;
			end else if (!charge_on_q && (lvl_s <= thr)) begin
				charge_next = 1'b1;
			end
		end
	end

	assign out_free  = ~out_valid_q | ~out_stall;
	assign q_pop     = (state_q == ST_IDLE) & q_valid;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q     <= q_code;
				power_q <= q_power;
				acc_q   <= bgch_pkg::POLY_C4;
				p_q     <= '0;
			end
			ST_MULT:  p_q    <= p_next;
			ST_ADD: begin
				acc_q <= acc_next;
				p_q   <= '0;
			end
			ST_ROUND: mv_q   <= 18'(q_mv) + 18'(cfg.adc_offset_mv);
			ST_SCALE: prod_q <= {prod_w[38], prod_w} + 40'sd32768;
			ST_LEVEL: begin
				if (prod_q[39]) begin
					lvl_q <= '0;
				end else if (|prod_q[38:30]) begin
					lvl_q <= bgch_pkg::LEVEL_MAX;
				end else begin
					lvl_q <= prod_q[29:16];
				end
			end
			ST_CLASS: begin
				rem_q <= 21'(diff) * 21'd100;
				den_q <= cfg.full_mv - cfg.empty_mv;
				if ((cfg.full_mv <= cfg.empty_mv) || (lvl_q <= cfg.empty_mv)) begin
					pct_q <= '0;
				end else if (lvl_q >= cfg.full_mv) begin
					pct_q <= bgch_pkg::PCT_FULL;
				end else begin
					pct_q <= '0;
				end
			end
			ST_DIV: begin
				if (rem_q >= trial) begin
					rem_q        <= rem_q - trial;
					pct_q[div_q] <= 1'b1;
				end
			end
			default: ;
		endcase
		if ((state_q == ST_FIN) && out_free) begin
			out_q.battery_mv    <= lvl_q;
			out_q.charge_enable <= charge_next & power_q;
			out_q.percent       <= pct_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= '0;
			step_q      <= '0;
			div_q       <= '0;
			charge_on_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: loaded from ST_FIN, held while stalled
			out_valid_q <= ((state_q == ST_FIN) && out_free) || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						bit_q   <= BIT_TOP;
						step_q  <= '0;
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					if (bit_q == '0) begin
						state_q <= ST_ADD;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_ADD: begin
					bit_q <= BIT_TOP;
					if (step_q == 2'd3) begin
						state_q <= ST_ROUND;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= ST_MULT;
					end
				end
				ST_ROUND: state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_LEVEL;
				ST_LEVEL: state_q <= ST_CLASS;
				ST_CLASS: begin
					div_q <= 3'd6;
					if ((cfg.full_mv <= cfg.empty_mv) || (lvl_q <= cfg.empty_mv)
						|| (lvl_q >= cfg.full_mv)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_q == 3'd0) begin
						state_q <= ST_FIN;
					end else begin
						div_q <= div_q - 3'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						charge_on_q <= charge_next;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/battery_gauge_charge_hysteresis_core.sv]
// Top level of the battery gauge with hysteresis charger control.
// Depends on bgch_pkg, bgch_regs, bgch_front, bgch_back.
//
// Each input beat carries one converter code and the power-present flag; each
// produces exactly one output beat with the battery voltage in mV (saturated to
// 0..16383), the charger drive (charging flag AND power present) and a 0..100
// percentage (0 when full_mv <= empty_mv). The code (low ADC_BITS bits) is
// linearized with a fixed quartic in Q48 fixed point, Horner form, with 64-bit
// saturation at every step, rounded half up to whole mV, offset, scaled by the
// Q16 inverse divider ratio and rounded. The front end takes beats into a
// two-entry queue, so up to two beats are taken while the back end is busy or a
// result waits in the output register. The back end works on one beat at a time:
// each of the four Horner steps runs a bit-serial shift-add multiply over the
// ADC_BITS code bits plus an add/saturate step, followed by rounding, scaling,
// clamping and classification, a restoring divide for the 7-bit percent only
// when the percent lies strictly between the limits, and a final state that
// loads the output register and waits while the output is stalled.
// Configuration registers sit at byte addresses 4*index on the APB-style port
// and may only be written while the block is idle.
module battery_gauge_charge_hysteresis_core #(
	parameter int ADC_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input beats
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bgch_pkg::in_beat_t          in_beat,
	// output beats
	output logic                        out_valid,
	input  logic                        out_stall,
	output bgch_pkg::out_beat_t         out_beat,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bgch_pkg::ADDR_W-1:0] paddr,
	input  logic [bgch_pkg::DATA_W-1:0] pwdata,
	output logic [bgch_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	bgch_pkg::cfg_t       cfg;
	logic                 q_valid;
	logic                 q_pop;
	logic [ADC_BITS-1:0]  q_code;
	logic                 q_power;

	bgch_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front end: accept, mask, queue
	bgch_front #(.ADC_BITS(ADC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_code   (q_code),
		.q_power  (q_power)
	);

	// back end: polynomial, scaling, charger, percent, output register
	bgch_back #(.ADC_BITS(ADC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_code    (q_code),
		.q_power   (q_power),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule
